FILE: rtl/pidlc_pkg.sv
// ----------------------------------------------------------------------------
// pidlc_pkg
// Shared types and constants for the illuminance PID controller: register
// indexes, multiplier operand selects and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package pidlc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF_RECIP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANTIWINDUP = 3'd7;

  localparam logic [15:0] DUTY_FULL = 16'd32768;

  // operand pair presented to the shared multiplier
  typedef enum logic [2:0] {
    MS_EXT_A,
    MS_EXT_B,
    MS_DERIV,
    MS_PROP,
    MS_INTEG,
    MS_FF
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     ext_save;
    logic     diff_save;
    logic     d_save;
    logic     pd_save;
    logic     acc_update;
    logic     res_load;
  } dp_cmd_t;

endpackage

FILE: rtl/pidlc_ctrl.sv
// ----------------------------------------------------------------------------
// pidlc_ctrl
// Sequencer for the controller: steps one sample through the shared
// multiplier and owns the input/output handshakes.
// ----------------------------------------------------------------------------
module pidlc_ctrl
  import pidlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    feedback_on,
  output dp_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL_FF = 10'b00_0000_0010,
    S_OUT_FF = 10'b00_0000_0100,
    S_MUL_A  = 10'b00_0000_1000,
    S_MUL_B  = 10'b00_0001_0000,
    S_SUM    = 10'b00_0010_0000,
    S_MUL_P  = 10'b00_0100_0000,
    S_MUL_I  = 10'b00_1000_0000,
    S_UPDATE = 10'b01_0000_0000,
    S_OUT_FB = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MS_EXT_A;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = feedback_on ? S_MUL_A : S_MUL_FF;
        end
      end
      S_MUL_FF: begin
        cmd.mul_sel = MS_FF;
        state_next  = S_OUT_FF;
      end
      S_OUT_FF: begin
        // keep the feedforward operands so the product holds while stalled
        cmd.mul_sel = MS_FF;
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MUL_A: begin
        cmd.mul_sel = MS_EXT_A;
        state_next  = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_sel  = MS_EXT_B;
        cmd.ext_save = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        cmd.mul_sel   = MS_DERIV;
        cmd.diff_save = 1'b1;
        state_next    = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_sel = MS_PROP;
        cmd.d_save  = 1'b1;
        state_next  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_sel = MS_INTEG;
        cmd.pd_save = 1'b1;
        state_next  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.acc_update = 1'b1;
        state_next     = S_OUT_FB;
      end
      S_OUT_FB: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/pidlc_dp.sv
// ----------------------------------------------------------------------------
// pidlc_dp
// Datapath: configuration registers, sample registers, shared 17x21 signed
// multiplier, integrator with saturation and anti-windup, output clamp.
// ----------------------------------------------------------------------------
module pidlc_dp
  import pidlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  input  logic [15:0]           reference_lux,
  input  logic [15:0]           measured_lux,
  input  logic [15:0]           neighbor_duty_a,
  input  logic [15:0]           neighbor_gain_a,
  input  logic [15:0]           neighbor_duty_b,
  input  logic [15:0]           neighbor_gain_b,
  output logic                  feedback_on,
  output logic [15:0]           duty_out
);

  logic [15:0] prop_gain, integ_gain, deriv_gain, ff_recip, duty_min, duty_max;
  logic        antiwindup_on;

  logic [15:0] ref_q, duty_a, gain_a, duty_b, gain_b;
  logic signed [16:0] err, prev_err;

  logic signed [16:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [37:0] prod;

  logic [31:0]        ext_sum;
  logic [32:0]        ext_total;
  logic signed [19:0] diff_p;
  logic signed [19:0] diff_p_next;
  logic signed [17:0] diff_d;
  logic signed [32:0] prod_sh;
  logic signed [32:0] d_term;
  logic signed [33:0] pd_sum;
  logic signed [31:0] acc;
  logic signed [34:0] u;
  logic signed [38:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic               hold;
  logic               err_pos, err_neg;

  function automatic logic [15:0] clamp_duty(input logic signed [34:0] v,
                                             input logic [15:0] lo,
                                             input logic [15:0] hi);
    logic signed [34:0] t;
    t = v;
    if (t > $signed({19'b0, hi})) t = $signed({19'b0, hi});
    if (t < $signed({19'b0, lo})) t = $signed({19'b0, lo});
    return t[15:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      ff_recip      <= '0;
      duty_min      <= '0;
      duty_max      <= DUTY_FULL;
      feedback_on   <= 1'b1;
      antiwindup_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain     <= cfg_data;
        REG_INTEG_GAIN: integ_gain    <= cfg_data;
        REG_DERIV_GAIN: deriv_gain    <= cfg_data;
        REG_FF_RECIP:   ff_recip      <= cfg_data;
        REG_DUTY_MIN:   duty_min      <= cfg_data;
        REG_DUTY_MAX:   duty_max      <= cfg_data;
        REG_FEEDBACK:   feedback_on   <= cfg_data[0];
        REG_ANTIWINDUP: antiwindup_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ref_q  <= reference_lux;
      err    <= $signed({1'b0, reference_lux}) - $signed({1'b0, measured_lux});
      duty_a <= neighbor_duty_a;
      gain_a <= neighbor_gain_a;
      duty_b <= neighbor_duty_b;
      gain_b <= neighbor_gain_b;
    end
  end

  assign diff_d = {err[16], err} - {prev_err[16], prev_err};

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MS_EXT_A: begin mul_a = {1'b0, gain_a};     mul_b = {5'b0, duty_a}; end
      MS_EXT_B: begin mul_a = {1'b0, gain_b};     mul_b = {5'b0, duty_b}; end
      MS_DERIV: begin mul_a = {1'b0, deriv_gain}; mul_b = {{3{diff_d[17]}}, diff_d}; end
      MS_PROP:  begin mul_a = {1'b0, prop_gain};  mul_b = {diff_p[19], diff_p}; end
      MS_INTEG: begin mul_a = {1'b0, integ_gain}; mul_b = {{4{err[16]}}, err}; end
      MS_FF:    begin mul_a = {1'b0, ff_recip};   mul_b = {5'b0, ref_q}; end
      default:  begin mul_a = '0;                 mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // neighbours' lux: sum of both products, Q.23 down to Q8.8
  assign ext_total   = {1'b0, ext_sum} + {1'b0, prod[31:0]};
  assign diff_p_next = {{3{err[16]}}, err} - $signed({2'b0, ext_total[32:15]});

  // >> 5 with floor is a plain bit select on two's complement
  assign prod_sh = prod[37:5];

  always_ff @(posedge clk) begin
    if (cmd.ext_save)  ext_sum <= prod[31:0];
    if (cmd.diff_save) diff_p  <= diff_p_next;
    if (cmd.d_save)    d_term  <= prod_sh;
    if (cmd.pd_save)   pd_sum  <= {prod_sh[32], prod_sh} + {d_term[32], d_term};
  end

  // u from the integrator as it stands; before and after the update
  assign u = {pd_sum[33], pd_sum} + {{12{acc[31]}}, acc[31:9]};

  assign err_pos = !err[16] && (err != '0);
  assign err_neg = err[16];
  assign hold = antiwindup_on &&
                ((u >= $signed({19'b0, duty_max}) && err_pos) ||
                 (u <= $signed({19'b0, duty_min}) && err_neg));

  assign acc_sum = {{7{acc[31]}}, acc} + {prod[37], prod};

  always_comb begin
    if (acc_sum[38:31] == '0 || acc_sum[38:31] == '1) begin
      acc_sat = acc_sum[31:0];
    end else if (acc_sum[38]) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      prev_err <= '0;
    end else if (cmd.acc_update) begin
      prev_err <= err;
      if (!hold) acc <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (feedback_on) begin
        duty_out <= clamp_duty(u, duty_min, duty_max);
      end else begin
        duty_out <= clamp_duty({{2{prod_sh[32]}}, prod_sh}, duty_min, duty_max);
      end
    end
  end

endmodule

FILE: rtl/pid_light_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_light_controller_antiwindup
// Luminaire duty controller: PID with conditional-integration anti-windup,
// or pure feedforward, with the output clamped to configured duty limits.
// ----------------------------------------------------------------------------
// One sample at a time: a new sample is taken only when the sequencer is back
// in idle. A feedback sample runs the two neighbour products, derivative,
// proportional and integral terms through the single shared 17x21 multiplier,
// then the integrator update and output; a feedforward sample is one product.
// A finished duty waits in the output register while the next sample is
// taken; it stalls the sequencer only if still untaken when the next is done.
// Configuration writes are registered and are expected only while idle.
module pid_light_controller_antiwindup
  import pidlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           reference_lux,
  input  logic [15:0]           measured_lux,
  input  logic [15:0]           neighbor_duty_a,
  input  logic [15:0]           neighbor_gain_a,
  input  logic [15:0]           neighbor_duty_b,
  input  logic [15:0]           neighbor_gain_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           duty_out
);

  dp_cmd_t cmd;
  logic    feedback_on;

  pidlc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .feedback_on (feedback_on),
    .cmd         (cmd)
  );

  pidlc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .reference_lux   (reference_lux),
    .measured_lux    (measured_lux),
    .neighbor_duty_a (neighbor_duty_a),
    .neighbor_gain_a (neighbor_gain_a),
    .neighbor_duty_b (neighbor_duty_b),
    .neighbor_gain_b (neighbor_gain_b),
    .feedback_on     (feedback_on),
    .duty_out        (duty_out)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the luminaire PID duty controller. A driver sends
// samples from a queue, a monitor predicts each duty at acceptance and checks
// it against the returned transaction in order. Directed corner cases come
// first, then phases of random samples under random and extreme settings.
// ----------------------------------------------------------------------------
module testbench;
  import pidlc_pkg::*;

  typedef struct packed {
    logic [15:0] setpoint;
    logic [15:0] measured;
    logic [15:0] duty_a;
    logic [15:0] gain_a;
    logic [15:0] duty_b;
    logic [15:0] gain_b;
  } sample_t;

  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           duty_out;
  sample_t               cur = '0;

  pid_light_controller_antiwindup uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .reference_lux   (cur.setpoint),
    .measured_lux    (cur.measured),
    .neighbor_duty_a (cur.duty_a),
    .neighbor_gain_a (cur.gain_a),
    .neighbor_duty_b (cur.duty_b),
    .neighbor_gain_b (cur.gain_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .duty_out        (duty_out)
  );

  always #1 clk = ~clk;

  // controller settings and loop state as the bench sees them
  logic [15:0]        kp, ki_ts, kd_ts, ff_recip, duty_lo, duty_hi;
  logic               fb_on, aw_on;
  logic signed [31:0] integ;
  logic [15:0]        prev_setpoint, prev_measured;

  sample_t     pending[$];
  logic [15:0] duty_expected[$];
  logic [15:0] want;
  logic        in_fire = 1'b0;
  logic        draining = 1'b0;
  logic        drained_once = 1'b0;
  int          gap = 0;
  int          stall = 0;
  int          idle_pct = 20;
  int unsigned accepted_cnt = 0, checked_cnt = 0, errors = 0;
  int unsigned ff_cnt = 0, hold_cnt = 0, sat_cnt = 0, settings_cnt = 0;

  function automatic logic [15:0] clamp_duty(input longint u);
    longint hi, lo;
    hi = longint'(duty_hi);
    lo = longint'(duty_lo);
    if (u > hi) u = hi;
    if (u < lo) u = lo;
    return u[15:0];
  endfunction

  // advances the loop state as the controller does for one sample
  function automatic logic [15:0] predict_duty(input sample_t s);
    longint sp, ms, da, ga, db, gb, err, err_prev, ext, p, d, acc, u;
    longint kpl, kil, kdl, ffl, hi, lo, psp, pms;
    logic   hold;
    sp = longint'(s.setpoint); ms = longint'(s.measured);
    da = longint'(s.duty_a); ga = longint'(s.gain_a);
    db = longint'(s.duty_b); gb = longint'(s.gain_b);
    kpl = longint'(kp); kil = longint'(ki_ts); kdl = longint'(kd_ts);
    ffl = longint'(ff_recip);
    hi = longint'(duty_hi); lo = longint'(duty_lo);
    psp = longint'(prev_setpoint); pms = longint'(prev_measured);
    if (!fb_on) begin
      ff_cnt++;
      return clamp_duty((sp * ffl) >>> 5);
    end
    err = sp - ms;
    err_prev = psp - pms;
    ext = (da * ga + db * gb) >>> 15;
    p = (kpl * (err - ext)) >>> 5;
    d = (kdl * (err - err_prev)) >>> 5;
    acc = longint'(integ);
    u = p + (acc >>> 9) + d;
    hold = aw_on && ((u >= hi && err > 0) || (u <= lo && err < 0));
    if (hold) begin
      hold_cnt++;
    end else begin
      acc = acc + kil * err;
      if (acc > ACC_MAX || acc < ACC_MIN) sat_cnt++;
      if (acc > ACC_MAX) acc = ACC_MAX;
      if (acc < ACC_MIN) acc = ACC_MIN;
      integ = acc[31:0];
    end
    u = p + (acc >>> 9) + d;
    prev_setpoint = s.setpoint;
    prev_measured = s.measured;
    return clamp_duty(u);
  endfunction

  // sender: one sample per transaction, random gaps and occasional full drain
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // payload held until taken
    end else if (gap != 0) begin
      in_valid <= 1'b0;
      gap <= gap - 1;
    end else if (draining) begin
      in_valid <= 1'b0;
      if (duty_expected.size() == 0) draining <= 1'b0;
    end else if (pending.size() == 0) begin
      in_valid <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      gap <= $urandom_range(0, 8);
    end else if (idle_pct != 0 && accepted_cnt >= 60 &&
                 (!drained_once || $urandom_range(0, 59) == 0)) begin
      in_valid <= 1'b0;
      draining <= 1'b1;
      drained_once <= 1'b1;
    end else begin
      in_valid <= 1'b1;
      cur <= pending.pop_front();
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall != 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_ready <= 1'b0;
      stall <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check returned duties first, then record the prediction for a new sample
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (duty_expected.size() == 0) begin
          $error("duty_out: transaction with nothing expected, got %0d", duty_out);
          errors++;
        end else begin
          want = duty_expected.pop_front();
          checked_cnt++;
          if (duty_out !== want) begin
            $error("duty_out mismatch: expected %0d, got %0d", want, duty_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        duty_expected.push_back(predict_duty(cur));
        accepted_cnt++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PROP_GAIN:  kp = val;
      REG_INTEG_GAIN: ki_ts = val;
      REG_DERIV_GAIN: kd_ts = val;
      REG_FF_RECIP:   ff_recip = val;
      REG_DUTY_MIN:   duty_lo = val;
      REG_DUTY_MAX:   duty_hi = val;
      REG_FEEDBACK:   fb_on = val[0];
      REG_ANTIWINDUP: aw_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input logic [15:0] p, i, d, f, lo, hi, input logic fb, aw);
    logic [15:0] w;
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_FF_RECIP, f);
    write_reg(REG_DUTY_MIN, lo);
    write_reg(REG_DUTY_MAX, hi);
    // flag registers get junk in the upper bits, which must be ignored
    w = 16'($urandom);
    w[0] = fb;
    write_reg(REG_FEEDBACK, w);
    w = 16'($urandom);
    w[0] = aw;
    write_reg(REG_ANTIWINDUP, w);
    settings_cnt++;
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, (1 << $urandom_range(4, 16)) - 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_duty();
    case ($urandom_range(0, 15))
      0, 1:    return 16'd0;
      2, 3:    return DUTY_FULL;
      4:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      m;
    s.setpoint = rand_word();
    case ($urandom_range(0, 3))
      0, 1: begin
        // settled loop: measurement close to the setpoint
        m = int'(s.setpoint) + int'($urandom_range(0, 1024)) - 512;
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
        s.measured = m[15:0];
      end
      2:       s.measured = rand_word();
      default: s.measured = s.setpoint;
    endcase
    s.duty_a = rand_duty();
    s.gain_a = rand_word();
    s.duty_b = rand_duty();
    s.gain_b = rand_word();
    return s;
  endfunction

  task automatic add(input logic [15:0] sp, ms, da, ga, db, gb);
    sample_t s;
    s.setpoint = sp; s.measured = ms;
    s.duty_a = da; s.gain_a = ga; s.duty_b = db; s.gain_b = gb;
    pending.push_back(s);
  endtask

  task automatic random_config();
    logic [15:0] lo, hi;
    case ($urandom_range(0, 7))
      0: begin
        lo = 16'($urandom_range(16384, 32768));
        hi = 16'($urandom_range(0, lo));
      end
      1: begin lo = 16'd0; hi = DUTY_FULL; end
      2: begin
        lo = 16'($urandom_range(0, 32768));
        hi = 16'($urandom_range(lo, 65535));
      end
      default: begin
        lo = 16'($urandom_range(0, 12000));
        hi = 16'($urandom_range(lo, 32768));
      end
    endcase
    apply_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), lo, hi,
                 $urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || duty_expected.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    kp = '0; ki_ts = '0; kd_ts = '0; ff_recip = '0;
    duty_lo = '0; duty_hi = DUTY_FULL; fb_on = 1'b1; aw_on = 1'b1;
    integ = '0; prev_setpoint = '0; prev_measured = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // settings straight out of reset
    add(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // unity gains: steady state, wind-up both ways, oversized neighbour duties
    apply_config(16'h1000, 16'h1000, 16'h0800, 16'h1000, 16'h0000, DUTY_FULL, 1'b1, 1'b1);
    add(16'h6400, 16'h6400, 16'h4000, 16'h3200, 16'h2000, 16'h1900);
    add(16'hC800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'hC800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'h0000, 16'hC800, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'h0000, 16'hC800, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'h1000, 16'h0F00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // no anti-windup, huge integral gain: accumulator hits both rails
    apply_config(16'h1000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, DUTY_FULL, 1'b1, 1'b0);
    repeat (3) add(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (3) add(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // feedforward only
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0100, 16'h7000, 1'b0, 1'b1);
    add(16'h0000, 16'h1111, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add(16'h1234, 16'h5678, 16'h1000, 16'h2000, 16'h3000, 16'h4000);
    wait_idle();

    // lower limit above upper limit: lower limit wins
    apply_config(16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'd20000, 16'd10000, 1'b1, 1'b1);
    add(16'h0100, 16'h0800, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add(16'hF000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();
    write_reg(REG_FEEDBACK, 16'h0000);
    add(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) idle_pct = 0;
      else if (ph == 0) idle_pct = 25;
      else idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if (ph == 0)
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, DUTY_FULL, 1'b1, 1'b1);
      else if (ph == 1)
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
      else
        random_config();
      for (int i = 0; i < 85; i++) pending.push_back(rand_sample());
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (duty_expected.size() != 0) begin
      $error("duty_out: %0d expected transactions never arrived", duty_expected.size());
      errors++;
    end
    $display("%0d samples under %0d controller settings, %0d duties checked",
             accepted_cnt, settings_cnt, checked_cnt);
    $display("%0d feedforward, %0d integrator holds, %0d accumulator saturations",
             ff_cnt, hold_cnt, sat_cnt);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #1000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
